// ===== hw/rtl/grid_cost_inflation_top_assert.svh =====
// ----------------------------------------------------------------------------
// grid_cost_inflation_top_assert
// Assertion macros for the grid cost inflation block.
// Each macro expects signals named clk and rst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef GRID_COST_INFLATION_TOP_ASSERT_SVH
`define GRID_COST_INFLATION_TOP_ASSERT_SVH

// Same-cycle implication.
`define CGI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CGI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cgi_pkg.sv =====
// ----------------------------------------------------------------------------
// cgi_pkg
// Shared types and constants of the grid cost inflation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cgi_pkg;

    localparam int GRID_DIM_DEF = 64;

    localparam int REQ_TYPE_W  = 2;
    localparam int COORD_IN_W  = 6;
    localparam int OCC_W       = 8;
    localparam int COST_W      = 8;
    localparam int DIM_REG_W   = 7;
    localparam int DAMP_W      = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_RUN   = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DAMPING     = 2'd2;

    localparam logic [DIM_REG_W-1:0] GRID_WIDTH_RST  = 7'd64;
    localparam logic [DIM_REG_W-1:0] GRID_HEIGHT_RST = 7'd64;
    localparam logic [DAMP_W-1:0]    DAMPING_RST     = 8'd26;

    localparam logic [COST_W-1:0] COST_MAX      = 8'hFF;
    localparam logic [OCC_W-1:0]  OCC_THRESHOLD = 8'h10;

    // Relaxation phase that writes the cell back
    localparam logic [3:0] PHASE_WRITE = 4'd9;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_RUN,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic [DIM_REG_W-1:0] grid_width;
        logic [DIM_REG_W-1:0] grid_height;
        logic [DAMP_W-1:0]    damping;
    } cfg_t;

    // Neighbour offsets, clockwise from the cell above
    function automatic logic signed [1:0] nb_dx(input logic [2:0] k);
        logic signed [1:0] d;
        case (k)
            3'd0:    d = 2'sd0;
            3'd1:    d = 2'sd1;
            3'd2:    d = 2'sd1;
            3'd3:    d = 2'sd1;
            3'd4:    d = 2'sd0;
            default: d = -2'sd1;
        endcase
        return d;
    endfunction

    function automatic logic signed [1:0] nb_dy(input logic [2:0] k);
        logic signed [1:0] d;
        case (k)
            3'd0:    d = -2'sd1;
            3'd1:    d = -2'sd1;
            3'd2:    d = 2'sd0;
            3'd3:    d = 2'sd1;
            3'd4:    d = 2'sd1;
            3'd5:    d = 2'sd1;
            3'd6:    d = 2'sd0;
            default: d = -2'sd1;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cgi_req_if.sv =====
// ----------------------------------------------------------------------------
// cgi_req_if
// Request channel: request type, cell coordinates and occupancy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cgi_req_if;
    logic                             valid;
    logic                             ready;
    logic [cgi_pkg::REQ_TYPE_W-1:0]   req_type;
    logic [cgi_pkg::COORD_IN_W-1:0]   cell_x;
    logic [cgi_pkg::COORD_IN_W-1:0]   cell_y;
    logic [cgi_pkg::OCC_W-1:0]        occupancy;

    modport source (output valid, req_type, cell_x, cell_y, occupancy, input ready);
    modport sink   (input valid, req_type, cell_x, cell_y, occupancy, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cgi_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cgi_rsp_if
// Response channel: cell cost and coordinate error flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cgi_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [cgi_pkg::COST_W-1:0]   cost;
    logic                         coord_error;

    modport source (output valid, cost, coord_error, input ready);
    modport sink   (input valid, cost, coord_error, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cgi_cfg_if.sv =====
// ----------------------------------------------------------------------------
// cgi_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cgi_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [cgi_pkg::CFG_INDEX_W-1:0]  index;
    logic [cgi_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cgi_cfg.sv =====
// ----------------------------------------------------------------------------
// cgi_cfg
// Configuration registers: grid width, grid height and damping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cgi_cfg (
    input  wire logic     clk,
    input  wire logic     rst_n,
    cgi_cfg_if.sink       cfg,
    output cgi_pkg::cfg_t regs
);

    logic [cgi_pkg::DIM_REG_W-1:0] width_reg;
    logic [cgi_pkg::DIM_REG_W-1:0] height_reg;
    logic [cgi_pkg::DAMP_W-1:0]    damping_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= cgi_pkg::GRID_WIDTH_RST;
            height_reg  <= cgi_pkg::GRID_HEIGHT_RST;
            damping_reg <= cgi_pkg::DAMPING_RST;
        end
        else if (cfg.valid)
        begin
            // Writes to unknown indexes are dropped
            case (cfg.index)
                cgi_pkg::REG_GRID_WIDTH:  width_reg   <= cfg.data[cgi_pkg::DIM_REG_W-1:0];
                cgi_pkg::REG_GRID_HEIGHT: height_reg  <= cfg.data[cgi_pkg::DIM_REG_W-1:0];
                cgi_pkg::REG_DAMPING:     damping_reg <= cfg.data[cgi_pkg::DAMP_W-1:0];
                default: ;
            endcase
        end
    end

    assign regs.grid_width  = width_reg;
    assign regs.grid_height = height_reg;
    assign regs.damping     = damping_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/cgi_mem.sv =====
// ----------------------------------------------------------------------------
// cgi_mem
// Cost store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cgi_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [AW-1:0]              waddr,
    input  wire logic [cgi_pkg::COST_W-1:0] wdata,
    input  wire logic                       re,
    input  wire logic [AW-1:0]              raddr,
    output logic      [cgi_pkg::COST_W-1:0] rdata
);

    logic [cgi_pkg::COST_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cgi_ctrl.sv =====
// ----------------------------------------------------------------------------
// cgi_ctrl
// Request sequencer: cell access, clearing sweep and two-pass relaxation
// over the cost store, with the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "grid_cost_inflation_top_assert.svh"

module cgi_ctrl #(
    parameter int GRID_DIM = 64,
    parameter int DEPTH    = 4096,
    parameter int AW       = 12,
    parameter int CW       = 6,
    parameter int DW       = 7
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    cgi_req_if.sink                         req,
    cgi_rsp_if.source                       rsp,
    input  cgi_pkg::cfg_t                   regs,
    output logic                            mem_we,
    output logic      [AW-1:0]              mem_waddr,
    output logic      [cgi_pkg::COST_W-1:0] mem_wdata,
    output logic                            mem_re,
    output logic      [AW-1:0]              mem_raddr,
    input  wire logic [cgi_pkg::COST_W-1:0] mem_rdata
);

    cgi_pkg::state_t state_reg, state_next;

    logic [CW-1:0]              x_reg, x_next;
    logic [CW-1:0]              y_reg, y_next;
    logic                       pass_reg, pass_next;
    logic [3:0]                 phase_reg, phase_next;
    logic [cgi_pkg::COST_W-1:0] best_reg, best_next;
    logic [AW-1:0]              clr_reg, clr_next;
    logic                       out_valid_reg, out_valid_next;
    logic [cgi_pkg::COST_W-1:0] out_cost_reg, out_cost_next;
    logic                       out_err_reg, out_err_next;

    logic [DW-1:0]              eff_w, eff_h;
    logic                       too_small;
    logic                       out_free;
    logic                       req_ready;
    logic                       accept;
    logic                       bad_coord;
    logic [AW-1:0]              req_addr;
    logic                       clr_last;
    logic [2:0]                 nb_idx;
    logic [CW-1:0]              nb_x, nb_y;
    logic [CW-1:0]              rd_x, rd_y;
    logic [8:0]                 diff;
    logic                       cand_ok;
    logic [cgi_pkg::COST_W-1:0] best_upd;
    logic                       y_at_end, x_at_end;
    logic                       y_at_one, x_at_one;
    logic                       run_done;

    function automatic logic [AW-1:0] addr_of(input logic [31:0] xx, input logic [31:0] yy);
        return AW'(xx * GRID_DIM + yy);
    endfunction

    // Sizes above the store act as the store size
    assign eff_w = (32'(regs.grid_width) > GRID_DIM) ? DW'(GRID_DIM) : DW'(regs.grid_width);
    assign eff_h = (32'(regs.grid_height) > GRID_DIM) ? DW'(GRID_DIM) : DW'(regs.grid_height);
    assign too_small = (32'(eff_w) < 32'd3) || (32'(eff_h) < 32'd3);

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req_ready = (state_reg == cgi_pkg::ST_IDLE) && out_free;
    assign accept    = req.valid && req_ready;
    assign req.ready = req_ready;

    assign bad_coord = (32'(req.cell_x) >= 32'(eff_w)) || (32'(req.cell_y) >= 32'(eff_h));
    assign req_addr  = addr_of(32'(req.cell_x), 32'(req.cell_y));
    assign clr_last  = (clr_reg == AW'(DEPTH - 1));

    // Phase 0 reads the cell, phases 1..8 read the neighbours
    assign nb_idx = 3'(phase_reg - 4'd1);
    assign nb_x   = x_reg + CW'(cgi_pkg::nb_dx(nb_idx));
    assign nb_y   = y_reg + CW'(cgi_pkg::nb_dy(nb_idx));
    assign rd_x   = (phase_reg == 4'd0) ? x_reg : nb_x;
    assign rd_y   = (phase_reg == 4'd0) ? y_reg : nb_y;

    // Data of the read issued one phase earlier
    assign diff    = {1'b0, mem_rdata} - {1'b0, regs.damping};
    assign cand_ok = !diff[8] && (diff[7:0] != cgi_pkg::COST_MAX) && (diff[7:0] > best_reg);
    assign best_upd = (phase_reg == 4'd1) ? mem_rdata :
                      (cand_ok ? diff[7:0] : best_reg);

    assign y_at_end = (32'(y_reg) == 32'(eff_h) - 32'd2);
    assign x_at_end = (32'(x_reg) == 32'(eff_w) - 32'd2);
    assign y_at_one = (y_reg == CW'(1));
    assign x_at_one = (x_reg == CW'(1));
    assign run_done = (phase_reg == cgi_pkg::PHASE_WRITE) && pass_reg && y_at_one && x_at_one;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cgi_pkg::ST_INIT:
            begin
                if (clr_last)
                    state_next = cgi_pkg::ST_IDLE;
            end
            cgi_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        cgi_pkg::REQ_READ:
                            state_next = bad_coord ? cgi_pkg::ST_IDLE : cgi_pkg::ST_READ;
                        cgi_pkg::REQ_RUN:
                            state_next = too_small ? cgi_pkg::ST_IDLE : cgi_pkg::ST_RUN;
                        cgi_pkg::REQ_CLEAR:
                            state_next = cgi_pkg::ST_CLEAR;
                        default:
                            state_next = cgi_pkg::ST_IDLE;
                    endcase
                end
            end
            cgi_pkg::ST_READ:
                state_next = cgi_pkg::ST_IDLE;
            cgi_pkg::ST_RUN:
            begin
                if (run_done)
                    state_next = cgi_pkg::ST_IDLE;
            end
            cgi_pkg::ST_CLEAR:
            begin
                if (clr_last)
                    state_next = cgi_pkg::ST_IDLE;
            end
            default:
                state_next = cgi_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        x_next         = x_reg;
        y_next         = y_reg;
        pass_next      = pass_reg;
        phase_next     = phase_reg;
        best_next      = best_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_cost_next  = out_cost_reg;
        out_err_next   = out_err_reg;
        mem_we         = 1'b0;
        mem_waddr      = clr_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = addr_of(32'(rd_x), 32'(rd_y));

        case (state_reg)
            cgi_pkg::ST_INIT,
            cgi_pkg::ST_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_last ? '0 : AW'(clr_reg + AW'(1));
                if (clr_last && (state_reg == cgi_pkg::ST_CLEAR))
                begin
                    out_valid_next = 1'b1;
                    out_cost_next  = '0;
                    out_err_next   = 1'b0;
                end
            end
            cgi_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        cgi_pkg::REQ_WRITE:
                        begin
                            mem_we         = !bad_coord;
                            mem_waddr      = req_addr;
                            mem_wdata      = (req.occupancy > cgi_pkg::OCC_THRESHOLD) ?
                                             cgi_pkg::COST_MAX : '0;
                            out_valid_next = 1'b1;
                            out_cost_next  = '0;
                            out_err_next   = bad_coord;
                        end
                        cgi_pkg::REQ_READ:
                        begin
                            mem_re    = !bad_coord;
                            mem_raddr = req_addr;
                            if (bad_coord)
                            begin
                                out_valid_next = 1'b1;
                                out_cost_next  = '0;
                                out_err_next   = 1'b1;
                            end
                        end
                        cgi_pkg::REQ_RUN:
                        begin
                            x_next     = CW'(1);
                            y_next     = CW'(1);
                            pass_next  = 1'b0;
                            phase_next = 4'd0;
                            if (too_small)
                            begin
                                out_valid_next = 1'b1;
                                out_cost_next  = '0;
                                out_err_next   = 1'b0;
                            end
                        end
                        default:
                        begin
                            clr_next = '0;
                        end
                    endcase
                end
            end
            cgi_pkg::ST_READ:
            begin
                out_valid_next = 1'b1;
                out_cost_next  = mem_rdata;
                out_err_next   = 1'b0;
            end
            cgi_pkg::ST_RUN:
            begin
                if (phase_reg != 4'd0)
                    best_next = best_upd;
                if (phase_reg == cgi_pkg::PHASE_WRITE)
                begin
                    // Write back; the next cell starts only after this write, so it sees this one
                    mem_we     = 1'b1;
                    mem_waddr  = addr_of(32'(x_reg), 32'(y_reg));
                    mem_wdata  = best_upd;
                    phase_next = 4'd0;
                    if (!pass_reg)
                    begin
                        if (y_at_end)
                        begin
                            if (x_at_end)
                            begin
                                pass_next = 1'b1;
                                x_next    = CW'(eff_w - DW'(2));
                                y_next    = CW'(eff_h - DW'(2));
                            end
                            else
                            begin
                                x_next = x_reg + CW'(1);
                                y_next = CW'(1);
                            end
                        end
                        else
                        begin
                            y_next = y_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        if (y_at_one)
                        begin
                            if (!x_at_one)
                            begin
                                x_next = x_reg - CW'(1);
                                y_next = CW'(eff_h - DW'(2));
                            end
                        end
                        else
                        begin
                            y_next = y_reg - CW'(1);
                        end
                    end
                    if (run_done)
                    begin
                        out_valid_next = 1'b1;
                        out_cost_next  = '0;
                        out_err_next   = 1'b0;
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    phase_next = phase_reg + 4'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cgi_pkg::ST_INIT;
            clr_reg       <= '0;
            phase_reg     <= 4'd0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            phase_reg     <= phase_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        best_reg     <= best_next;
        out_cost_reg <= out_cost_next;
        out_err_reg  <= out_err_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.cost        = out_cost_reg;
    assign rsp.coord_error = out_err_reg;

    `CGI_ASSERT_IMP(a_no_rw_collision, mem_we && mem_re, mem_waddr != mem_raddr,
                    "read and write hit the same cell in one cycle")
    `CGI_ASSERT_IMP(a_run_interior, state_reg == cgi_pkg::ST_RUN,
                    (x_reg != '0) && (y_reg != '0), "relaxation left the interior")
    `CGI_ASSERT_NXT(a_read_goes_wait,
                    accept && (req.req_type == cgi_pkg::REQ_READ) && !bad_coord,
                    state_reg == cgi_pkg::ST_READ, "read did not wait for store data")
    `CGI_ASSERT_IMP(a_init_no_response, state_reg == cgi_pkg::ST_INIT, !out_valid_reg,
                    "response raised during the reset clearing pass")

endmodule

`default_nettype wire

// ===== hw/rtl/grid_cost_inflation_top.sv =====
// ----------------------------------------------------------------------------
// grid_cost_inflation_top
// Cost grid with cell write/read, clear and two-pass chamfer inflation.
// ----------------------------------------------------------------------------
// After reset the block sweeps the cost store to zero, one cell per cycle, over
// all GRID_DIM*GRID_DIM cells (4096 at the default size); no request is taken
// until the sweep ends, while configuration writes are taken at any time. A
// cell write goes straight to the store, while a cell read waits in the read
// state for its data, since the store has a registered read port; a clear
// sweeps every cell to zero as after reset. A run relaxes each interior cell
// through the single read port, nine reads and one write-back, in a forward
// and a backward pass over the w by h cells in use. Every request returns
// exactly one response, held in an output register; the next request is taken
// no earlier than the cycle in which that response is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_cost_inflation_top #(
    parameter int GRID_DIM = cgi_pkg::GRID_DIM_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cgi_req_if.sink   req,
    cgi_rsp_if.source rsp,
    cgi_cfg_if.sink   cfg
);

    localparam int DEPTH = GRID_DIM * GRID_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(GRID_DIM);
    localparam int DW    = $clog2(GRID_DIM + 1);

    cgi_pkg::cfg_t              regs;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [cgi_pkg::COST_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [AW-1:0]              mem_raddr;
    logic [cgi_pkg::COST_W-1:0] mem_rdata;

    cgi_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    cgi_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    cgi_ctrl #(
        .GRID_DIM (GRID_DIM),
        .DEPTH    (DEPTH),
        .AW       (AW),
        .CW       (CW),
        .DW       (DW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .regs      (regs),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

endmodule

`default_nettype wire
